@@ rtl/domain_name_label_encoder_defines.svh @@
// Assertion macros shared by the domain name label encoder RTL.
// Expects signals clk and rst_n in the including module's scope.
`ifndef DOMAIN_NAME_LABEL_ENCODER_DEFINES_SVH
`define DOMAIN_NAME_LABEL_ENCODER_DEFINES_SVH

// Check a condition at every rising clock edge outside reset.
`define DNLE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define DNLE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/dnle_pkg.sv @@
// Package for the domain name label encoder: constants, status codes,
// result and push types. No dependencies.
package dnle_pkg;

    localparam int MAX_NAME_CHARS  = 255;
    localparam int MAX_LABEL_LEN   = 63;
    localparam int MAX_CHAR_OFFSET = 253;
    localparam int MAX_RESULTS     = 3;
    localparam logic [7:0] DOT_CHAR = 8'h2E;

    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = PTR_W + 1;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_EMPTY_LABEL = 2'd1,
        STATUS_LABEL_LONG  = 2'd2,
        STATUS_NAME_LONG   = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [7:0] out_offset;
        logic       is_last;
        status_t    status;
    } res_t;

    typedef struct packed {
        logic [1:0]                 n;
        res_t [MAX_RESULTS-1:0]     r;
    } push_t;

    function automatic res_t mk_res(input logic [7:0] b, input logic [7:0] off,
                                    input logic last, input status_t st);
        res_t r;
        r.out_byte   = b;
        r.out_offset = off;
        r.is_last    = last;
        r.status     = st;
        return r;
    endfunction

endpackage

@@ rtl/domain_name_label_encoder.sv @@
// Top level of the domain name label encoder: input register, encoder core
// and result queue. Depends on dnle_pkg, dnle_core and dnle_fifo.
//
// Usage:
//   Slave stream carries one byte of a dotted name per transaction:
//   s_tdata = name byte, s_tuser = has_char (byte is valid), s_tlast = name end.
//   Master stream carries one wire byte per transaction: m_tdata holds the
//   byte and its offset in the encoded name, m_tlast marks the final result
//   of a name (error results too), m_tuser holds the status code.
// Flow: an accepted transaction is held in the input register, its results
//   are computed from that register and written into an 8-entry result
//   queue; the first result is valid once written and leaves on m_tready.
// Throughput: one input transaction per cycle while the master side takes
//   one result per cycle. A dot gives up to two results and a name end up to
//   three, drained one per cycle; s_tready drops when the queue cannot hold
//   three results each for the registered transaction and the next one.
// Reset: rst_n clears the encoder state, input valid flag and queue pointers;
//   the block then expects the start of a new name.
// Stall: when m_tready is low, results hold in the queue and s_tready falls
//   once the queue is near full; nothing is lost or repeated.
module domain_name_label_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_char
    input  logic [0:0]  s_tuser,   // [0] has_char
    input  logic        s_tlast,   // is_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [15:8] out_offset
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast    // is_last
);
    import dnle_pkg::*;

    logic             in_valid_reg;
    logic [7:0]       in_char_reg;
    logic             has_char_reg;
    logic             is_end_reg;
    logic             accept;
    push_t            push;
    res_t             head;
    logic [CNT_W-1:0] count;
    logic [CNT_W:0]   reserved;

    // reserve room for the worst case of the item still in the input register
    assign reserved = {1'b0, count} + (in_valid_reg ? (CNT_W+1)'(MAX_RESULTS) : '0);
    assign s_tready = reserved <= (CNT_W+1)'(FIFO_DEPTH - MAX_RESULTS);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= accept;
    end

    // payload: hold the accepted transaction for the encoder core
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_char_reg  <= s_tdata;
            has_char_reg <= s_tuser[0];
            is_end_reg   <= s_tlast;
        end
    end

    dnle_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid_reg),
        .in_char  (in_char_reg),
        .has_char (has_char_reg),
        .is_end   (is_end_reg),
        .push     (push)
    );

    dnle_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop_ready  (m_tready),
        .head       (head),
        .head_valid (m_tvalid),
        .count      (count)
    );

    assign m_tdata = {head.out_offset, head.out_byte};
    assign m_tuser = head.status;
    assign m_tlast = head.is_last;

endmodule

@@ rtl/dnle_core.sv @@
// Encoder state and per-item result logic for the domain name label encoder.
// Depends on dnle_pkg and domain_name_label_encoder_defines.svh.
`include "domain_name_label_encoder_defines.svh"

module dnle_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [7:0]          in_char,
    input  logic                has_char,
    input  logic                is_end,
    output dnle_pkg::push_t     push
);
    import dnle_pkg::*;

    logic [7:0] write_pos_reg,   write_pos_next;
    logic [7:0] label_start_reg, label_start_next;
    logic [5:0] label_len_reg,   label_len_next;
    logic [7:0] char_count_reg,  char_count_next;
    logic       discarding_reg,  discarding_next;

    logic [8:0] cc_wide;
    logic [7:0] off;
    logic       cc_ovf;
    logic       off_ovf;
    logic       lone_dot;
    logic       is_dot;
    logic       do_fault;
    logic       do_clear;
    status_t    fault_code;

    assign cc_wide  = {1'b0, char_count_reg} + 9'd1;
    assign cc_ovf   = cc_wide > 9'(MAX_NAME_CHARS);
    assign off      = write_pos_reg + 8'd1;
    assign off_ovf  = write_pos_reg >= 8'(MAX_CHAR_OFFSET);
    assign lone_dot = (char_count_reg == 8'd1) && (write_pos_reg == 8'd0)
                      && (label_len_reg == 6'd0);
    assign is_dot   = in_char == DOT_CHAR;

    always_comb
    begin
        write_pos_next   = write_pos_reg;
        label_start_next = label_start_reg;
        label_len_next   = label_len_reg;
        char_count_next  = char_count_reg;
        discarding_next  = discarding_reg;
        push             = '0;
        do_fault         = 1'b0;
        do_clear         = 1'b0;
        fault_code       = STATUS_OK;

        if (in_valid)
        begin
            if (discarding_reg)
            begin
                // drop everything up to the name end
                if (is_end)
                    do_clear = 1'b1;
            end
            else if (has_char)
            begin
                if (cc_ovf)
                begin
                    do_fault   = 1'b1;
                    fault_code = STATUS_NAME_LONG;
                end
                else if (is_dot)
                begin
                    if (label_len_reg == 6'd0)
                    begin
                        if ((char_count_reg == 8'd0) && is_end)
                        begin
                            // lone dot: root name
                            push.r[0] = mk_res(8'd0, 8'd0, 1'b1, STATUS_OK);
                            push.n    = 2'd1;
                            do_clear  = 1'b1;
                        end
                        else
                        begin
                            do_fault   = 1'b1;
                            fault_code = STATUS_EMPTY_LABEL;
                        end
                    end
                    else
                    begin
                        push.r[0] = mk_res({2'b0, label_len_reg}, label_start_reg,
                                           1'b0, STATUS_OK);
                        push.n    = 2'd1;
                        if (is_end)
                        begin
                            push.r[1] = mk_res(8'd0, off, 1'b1, STATUS_OK);
                            push.n    = 2'd2;
                            do_clear  = 1'b1;
                        end
                        else
                        begin
                            label_start_next = off;
                            write_pos_next   = off;
                            label_len_next   = 6'd0;
                            char_count_next  = cc_wide[7:0];
                        end
                    end
                end
                else
                begin
                    if (lone_dot)
                    begin
                        do_fault   = 1'b1;
                        fault_code = STATUS_EMPTY_LABEL;
                    end
                    else if (label_len_reg == 6'(MAX_LABEL_LEN))
                    begin
                        do_fault   = 1'b1;
                        fault_code = STATUS_LABEL_LONG;
                    end
                    else if (off_ovf)
                    begin
                        do_fault   = 1'b1;
                        fault_code = STATUS_NAME_LONG;
                    end
                    else
                    begin
                        push.r[0] = mk_res(in_char, off, 1'b0, STATUS_OK);
                        push.n    = 2'd1;
                        if (is_end)
                        begin
                            push.r[1] = mk_res({2'b0, label_len_reg} + 8'd1,
                                               label_start_reg, 1'b0, STATUS_OK);
                            push.r[2] = mk_res(8'd0, off + 8'd1, 1'b1, STATUS_OK);
                            push.n    = 2'd3;
                            do_clear  = 1'b1;
                        end
                        else
                        begin
                            write_pos_next  = off;
                            label_len_next  = label_len_reg + 6'd1;
                            char_count_next = cc_wide[7:0];
                        end
                    end
                end
            end
            else if (is_end)
            begin
                if (label_len_reg != 6'd0)
                begin
                    push.r[0] = mk_res({2'b0, label_len_reg}, label_start_reg,
                                       1'b0, STATUS_OK);
                    push.r[1] = mk_res(8'd0, off, 1'b1, STATUS_OK);
                    push.n    = 2'd2;
                end
                else
                begin
                    push.r[0] = mk_res(8'd0, label_start_reg, 1'b1, STATUS_OK);
                    push.n    = 2'd1;
                end
                do_clear = 1'b1;
            end
        end

        if (do_fault)
        begin
            push.r[0] = mk_res(8'd0, 8'd0, 1'b1, fault_code);
            push.n    = 2'd1;
            do_clear  = 1'b1;
        end

        if (do_clear)
        begin
            write_pos_next   = 8'd0;
            label_start_next = 8'd0;
            label_len_next   = 6'd0;
            char_count_next  = 8'd0;
            discarding_next  = do_fault && !is_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_pos_reg   <= '0;
            label_start_reg <= '0;
            label_len_reg   <= '0;
            char_count_reg  <= '0;
            discarding_reg  <= 1'b0;
        end
        else
        begin
            write_pos_reg   <= write_pos_next;
            label_start_reg <= label_start_next;
            label_len_reg   <= label_len_next;
            char_count_reg  <= char_count_next;
            discarding_reg  <= discarding_next;
        end
    end

    `DNLE_ASSERT_ALWAYS(a_pos_tracks_label, write_pos_reg == label_start_reg + {2'b0, label_len_reg}, "write position out of step with label")
    `DNLE_ASSERT_IMPL(a_discard_clean, discarding_reg, (char_count_reg == 8'd0) && (label_len_reg == 6'd0), "state not cleared while discarding")

endmodule

@@ rtl/dnle_fifo.sv @@
// Result queue for the domain name label encoder: takes up to three results
// per cycle, delivers one. Depends on dnle_pkg and the defines header.
`include "domain_name_label_encoder_defines.svh"

module dnle_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dnle_pkg::push_t        push,
    input  logic                   pop_ready,
    output dnle_pkg::res_t         head,
    output logic                   head_valid,
    output logic [dnle_pkg::CNT_W-1:0] count
);
    import dnle_pkg::*;

    res_t             entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             pop;

    assign head_valid  = count_reg != '0;
    assign head        = entry_reg[rd_ptr_reg];
    assign count       = count_reg;
    assign pop         = pop_ready && head_valid;
    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push.n);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(push.n) - CNT_W'(pop);

    // store the new results in arrival order
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            if (k < int'(push.n))
                entry_reg[wr_ptr_reg + PTR_W'(k)] <= push.r[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `DNLE_ASSERT_ALWAYS(a_no_overflow, ({1'b0, count_reg} + (CNT_W+1)'(push.n)) <= ((CNT_W+1)'(FIFO_DEPTH) + (CNT_W+1)'(pop)), "result queue overflow")
    `DNLE_ASSERT_IMPL(a_ptr_gap, count_reg != (CNT_W)'(FIFO_DEPTH), PTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[PTR_W-1:0], "queue pointers disagree with count")

endmodule

@@ sim/testbench.sv @@
// Self-checking bench for domain_name_label_encoder: drives dotted names over the
// slave stream and compares every wire byte against an in-bench label encoder.
// Depends on dnle_pkg and the RTL top level.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dnle_pkg::*;

    localparam int RUN_LIMIT_NS = 2_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS = 100;

    typedef enum bit {
        END_WITH_LAST,
        END_SEPARATE
    } end_style_t;

    // Tracks the wire encoding of the current name and holds the bytes it owes.
    class wire_name_scoreboard;
        res_t       wire_bytes_due[$];
        int         errors;
        logic [8:0] write_pos;
        logic [7:0] label_start;
        logic [6:0] label_len;
        logic [8:0] char_count;
        bit         discarding;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            write_pos   = '0;
            label_start = '0;
            label_len   = '0;
            char_count  = '0;
            discarding  = 1'b0;
        endfunction

        function void owe(logic [7:0] b, logic [7:0] off, logic last, status_t st);
            res_t r;
            r.out_byte   = b;
            r.out_offset = off;
            r.is_last    = last;
            r.status     = st;
            wire_bytes_due.push_back(r);
        endfunction

        // One error byte, then drop the rest of the name unless it ends here.
        function void reject(status_t st, bit fin);
            owe(8'd0, 8'd0, 1'b1, st);
            restart();
            discarding = !fin;
        endfunction

        function void note_input(logic [7:0] ch, bit has, bit fin);
            int cc;
            int off;
            bit lone_dot;
            if (discarding)
            begin
                if (fin)
                    restart();
                return;
            end
            if (has)
            begin
                cc = char_count + 1;
                lone_dot = (char_count == 1 && write_pos == 0 && label_len == 0);
                if (cc > MAX_NAME_CHARS)
                begin
                    reject(STATUS_NAME_LONG, fin);
                    return;
                end
                if (ch == DOT_CHAR)
                begin
                    if (label_len == 0)
                    begin
                        // a lone dot that closes the name is the root name
                        if (char_count == 0 && fin)
                        begin
                            owe(8'd0, 8'd0, 1'b1, STATUS_OK);
                            restart();
                        end
                        else
                            reject(STATUS_EMPTY_LABEL, fin);
                        return;
                    end
                    owe(8'(label_len), label_start, 1'b0, STATUS_OK);
                    if (fin)
                    begin
                        owe(8'd0, 8'(write_pos + 1), 1'b1, STATUS_OK);
                        restart();
                        return;
                    end
                    label_start = 8'(write_pos + 1);
                    write_pos   = 9'(label_start);
                    label_len   = '0;
                    char_count  = 9'(cc);
                    return;
                end
                off = write_pos + 1;
                if (lone_dot)
                begin
                    reject(STATUS_EMPTY_LABEL, fin);
                    return;
                end
                if (label_len + 1 > MAX_LABEL_LEN)
                begin
                    reject(STATUS_LABEL_LONG, fin);
                    return;
                end
                if (off > MAX_CHAR_OFFSET)
                begin
                    reject(STATUS_NAME_LONG, fin);
                    return;
                end
                owe(ch, 8'(off), 1'b0, STATUS_OK);
                write_pos  = 9'(off);
                label_len  = label_len + 7'd1;
                char_count = 9'(cc);
                if (fin)
                begin
                    owe(8'(label_len), label_start, 1'b0, STATUS_OK);
                    owe(8'd0, 8'(off + 1), 1'b1, STATUS_OK);
                    restart();
                end
                return;
            end
            if (fin)
            begin
                if (label_len > 0)
                begin
                    owe(8'(label_len), label_start, 1'b0, STATUS_OK);
                    owe(8'd0, 8'(write_pos + 1), 1'b1, STATUS_OK);
                end
                else
                    // empty name or trailing dot: just the closing zero
                    owe(8'd0, label_start, 1'b1, STATUS_OK);
                restart();
            end
        endfunction

        function void check_result(logic [15:0] data, logic [1:0] user, logic last);
            res_t want;
            if (wire_bytes_due.size() == 0)
            begin
                $error("unexpected result: out_byte %0d out_offset %0d is_last %0d status %0d",
                       data[7:0], data[15:8], last, user);
                errors++;
                return;
            end
            want = wire_bytes_due.pop_front();
            if (data[7:0] !== want.out_byte)
            begin
                $error("out_byte: expected %0d, actual %0d", want.out_byte, data[7:0]);
                errors++;
            end
            if (data[15:8] !== want.out_offset)
            begin
                $error("out_offset: expected %0d, actual %0d", want.out_offset, data[15:8]);
                errors++;
            end
            if (last !== want.is_last)
            begin
                $error("is_last: expected %0d, actual %0d", want.is_last, last);
                errors++;
            end
            if (user !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, user);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic [0:0]  s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    wire_name_scoreboard sb;
    logic [7:0] name_buf[$];
    bit quiet = 1'b0;
    int items_sent = 0;
    int ready_hold = 0;

    domain_name_label_encoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver: stall in random bursts, never once the run goes quiet.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            ready_hold = 0;
        end
        else if (quiet)
            m_tready <= 1'b1;
        else if (ready_hold > 0)
        begin
            ready_hold--;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            ready_hold = $urandom_range(1, 17) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser, m_tlast);
    end

    // Present one transaction, hold it until accepted, then log it.
    task automatic send_item(input logic [7:0] ch, input bit has, input bit fin);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= has;
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_input(ch, has, fin);
        if (has || fin)
            items_sent++;
    endtask

    // Drop valid and hold off until every owed wire byte has come out.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.wire_bytes_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_label(input int len);
        logic [7:0] c;
        for (int i = 0; i < len; i++)
        begin
            c = 8'($urandom_range(0, 255));
            if (c == DOT_CHAR)
                c = c ^ 8'($urandom_range(1, 255));
            name_buf.push_back(c);
        end
    endtask

    task automatic build_name(input int labels, input int min_len, input int max_len,
                              input bit trailing_dot);
        name_buf.delete();
        for (int i = 0; i < labels; i++)
        begin
            if (i != 0)
                name_buf.push_back(DOT_CHAR);
            add_label($urandom_range(min_len, max_len));
        end
        if (trailing_dot)
            name_buf.push_back(DOT_CHAR);
    endtask

    // Send name_buf with the occasional idle transaction mixed in.
    task automatic send_name(input end_style_t style);
        bit fin;
        for (int i = 0; i < name_buf.size(); i++)
        begin
            if (!quiet && $urandom_range(0, 9) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            fin = (i == name_buf.size() - 1) && (style == END_WITH_LAST);
            send_item(name_buf[i], 1'b1, fin);
        end
        if (style == END_SEPARATE || name_buf.size() == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic random_end_style(output end_style_t style);
        style = $urandom_range(0, 1) ? END_SEPARATE : END_WITH_LAST;
    endtask

    initial
    begin
        #RUN_LIMIT_NS;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        end_style_t style;
        int kind;
        int len;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty name, root name, short names, in-band bytes, faults
        send_item(8'h00, 1'b0, 1'b1);
        send_item(DOT_CHAR, 1'b1, 1'b1);
        send_item("a", 1'b1, 1'b1);
        send_item("a", 1'b1, 1'b0);
        send_item("b", 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        send_item("x", 1'b1, 1'b0);
        send_item(DOT_CHAR, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item("q", 1'b1, 1'b0);
        send_item(DOT_CHAR, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h55, 1'b0, 1'b0);
        send_item("a", 1'b1, 1'b0);
        send_item(DOT_CHAR, 1'b1, 1'b0);
        send_item("b", 1'b1, 1'b1);
        send_item(DOT_CHAR, 1'b1, 1'b0);
        send_item("z", 1'b1, 1'b0);
        send_item(8'hAA, 1'b0, 1'b1);
        send_item("a", 1'b1, 1'b0);
        send_item(DOT_CHAR, 1'b1, 1'b0);
        send_item(DOT_CHAR, 1'b1, 1'b1);

        drain_results();

        // widest cases: full label, label one over, wire name at and past 255 bytes
        name_buf.delete();
        add_label(MAX_LABEL_LEN);
        random_end_style(style);
        send_name(style);
        name_buf.delete();
        add_label(MAX_LABEL_LEN + 1);
        send_name(END_SEPARATE);
        for (int extra = 0; extra < 2; extra++)
        begin
            name_buf.delete();
            for (int i = 0; i < 3; i++)
            begin
                add_label(MAX_LABEL_LEN);
                name_buf.push_back(DOT_CHAR);
            end
            add_label(61 + extra);
            send_name(END_WITH_LAST);
        end

        // random: mostly well-formed names, some broken ones and noise
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            random_end_style(style);
            if (kind < 60)
            begin
                build_name($urandom_range(1, 4), 1, 8, $urandom_range(0, 3) == 0);
                send_name(style);
            end
            else if (kind < 66)
            begin
                len = $urandom_range(58, 64);
                build_name($urandom_range(1, 2), len, len, 1'b0);
                send_name(style);
            end
            else if (kind < 80)
            begin
                build_name($urandom_range(2, 4), 1, 6, 1'b0);
                // break it: leading dot or doubled dot
                if ($urandom_range(0, 1))
                    name_buf.push_front(DOT_CHAR);
                else
                    foreach (name_buf[i])
                        if (name_buf[i] == DOT_CHAR)
                        begin
                            name_buf.insert(i, DOT_CHAR);
                            break;
                        end
                send_name(style);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_item($urandom_range(0, 3) == 0 ? DOT_CHAR : 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 1'b0);
                send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            end
        end

        // last stretch runs with no idling on either side
        quiet = 1'b1;
        repeat (6)
        begin
            random_end_style(style);
            build_name($urandom_range(1, 3), 1, 8, 1'($urandom_range(0, 1)));
            send_name(style);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.wire_bytes_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
